// ===== src/qlm_pkg.sv =====
// Package for the queued lock manager: codes, types and default sizes.
`timescale 1ns / 1ps

package qlm_pkg;

  localparam int KIND_W   = 2;
  localparam int IDX_W    = 6;
  localparam int NODE_W   = 5;
  localparam int STATUS_W = 3;

  localparam int DEF_NUM_LOCKS = 64;
  localparam int DEF_MAX_NODES = 32;
  localparam int DEF_SEQ_BITS  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT   = 2'd0,
    KIND_LOCK   = 2'd1,
    KIND_UNLOCK = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_QUEUED    = 3'd1,
    STS_UNKNOWN   = 3'd2,
    STS_NOT_OWNER = 3'd3,
    STS_NOT_HELD  = 3'd4,
    STS_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DEQ
  } state_t;

  // Decision for one request, from the decide logic to the sequencer
  typedef struct packed {
    status_t status;
    logic    send;
    logic    tbl_we;
    logic    q_we;
    logic    q_re;
    logic    from_waiter;
  } dec_t;

endpackage

// ===== src/queued_lock_manager_core.sv =====
// Top level of the queued lock manager: sequencer, lock table, waiter store, result register.
`timescale 1ns / 1ps

//  channel | ports                                              | dir | handshake
//  --------+----------------------------------------------------+-----+----------------
//  in      | in_kind, in_lock_index, in_source_node, in_source_seq | in  | in_valid/in_ready
//  out     | out_status, out_send_valid, out_dest_node, out_dest_seq | out | out_valid/out_ready
//
// One item at a time: accept, then read the lock entry, then decide and write back.
// An unlock that hands over to a waiter takes an extra step, the read of the waiter store.
// The sequencer holds the lock-table port throughout, so a following item to the same lock
// always sees the written-back entry.
// After reset a clearing pass writes every lock-table entry to zero, with in_ready low
// throughout. The waiter store is never cleared; a queue only reads slots it has pushed.
// A result waits in the output register; the next item is still accepted, and only its
// final cycle stalls until the register is free.

module queued_lock_manager_core #(
  parameter int NUM_LOCKS = qlm_pkg::DEF_NUM_LOCKS,
  parameter int MAX_NODES = qlm_pkg::DEF_MAX_NODES,
  parameter int SEQ_BITS  = qlm_pkg::DEF_SEQ_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qlm_pkg::KIND_W-1:0]    in_kind,
  input  logic [qlm_pkg::IDX_W-1:0]     in_lock_index,
  input  logic [qlm_pkg::NODE_W-1:0]    in_source_node,
  input  logic [SEQ_BITS-1:0]           in_source_seq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qlm_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_send_valid,
  output logic [qlm_pkg::NODE_W-1:0]    out_dest_node,
  output logic [SEQ_BITS-1:0]           out_dest_seq
);

  import qlm_pkg::*;

  localparam int LI_W  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int HD_W  = $clog2(MAX_NODES);
  localparam int CT_W  = $clog2(MAX_NODES + 1);
  localparam int ENT_W = 2 + NODE_W + HD_W + CT_W;
  localparam int WQ_D  = NUM_LOCKS * MAX_NODES;
  localparam int WA_W  = $clog2(WQ_D);
  localparam int WQ_W  = NODE_W + SEQ_BITS;

  // Sequencer
  state_t state_r, state_nxt;
  logic [LI_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Captured request (payload, no reset)
  kind_t               req_kind_r;
  logic [IDX_W-1:0]    req_idx_r;
  logic [NODE_W-1:0]   req_node_r;
  logic [SEQ_BITS-1:0] req_seq_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic                out_send_r;
  logic [NODE_W-1:0]   out_node_r;
  logic [SEQ_BITS-1:0] out_seq_r;

  logic accept;
  logic out_free;
  logic act;
  logic commit;
  logic req_idx_ok;
  logic [LI_W-1:0] li;

  // Lock table
  logic              tbl_we;
  logic [LI_W-1:0]   tbl_waddr;
  logic [ENT_W-1:0]  tbl_wdata;
  logic [ENT_W-1:0]  tbl_rdata;
  logic              ent_exists, ent_held;
  logic [NODE_W-1:0] ent_owner;
  logic [HD_W-1:0]   ent_head;
  logic [CT_W-1:0]   ent_count;

  // Waiter store
  logic              wq_we, wq_re;
  logic [WA_W-1:0]   wq_addr;
  logic [WQ_W-1:0]   wq_rdata;
  logic [NODE_W-1:0] waiter_node;
  logic [SEQ_BITS-1:0] waiter_seq;

  // Decision
  dec_t              dec;
  logic              new_exists, new_held;
  logic [NODE_W-1:0] new_owner;
  logic [HD_W-1:0]   new_head;
  logic [CT_W-1:0]   new_count;
  logic [HD_W-1:0]   slot;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign req_idx_ok = (32'(req_idx_r) < 32'(NUM_LOCKS));
  assign li         = LI_W'(req_idx_r);

  assign {ent_exists, ent_held, ent_owner, ent_head, ent_count} = tbl_rdata;
  assign {waiter_node, waiter_seq} = wq_rdata;

  qlm_decide #(
    .MAX_NODES (MAX_NODES)
  ) u_decide (
    .deq_phase   (state_r == S_DEQ),
    .req_kind    (req_kind_r),
    .req_idx_ok  (req_idx_ok),
    .req_node    (req_node_r),
    .ent_exists  (ent_exists),
    .ent_held    (ent_held),
    .ent_owner   (ent_owner),
    .ent_head    (ent_head),
    .ent_count   (ent_count),
    .waiter_node (waiter_node),
    .dec         (dec),
    .new_exists  (new_exists),
    .new_held    (new_held),
    .new_owner   (new_owner),
    .new_head    (new_head),
    .new_count   (new_count),
    .slot        (slot)
  );

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    act         = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + LI_W'(1);
        if (clr_cnt_r == LI_W'(NUM_LOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        // A waiter fetch makes no result yet, so it need not wait for the output
        act = dec.q_re || out_free;
        if (act) begin
          state_nxt = dec.q_re ? S_DEQ : S_IDLE;
        end
      end
      S_DEQ: begin
        act = out_free;
        if (act) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign commit = act && !dec.q_re;

  // Lock table port: clearing pass after reset, else write-back of the decided entry
  always_comb begin
    if (state_r == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_cnt_r;
      tbl_wdata = '0;
    end else begin
      tbl_we    = act && dec.tbl_we;
      tbl_waddr = li;
      tbl_wdata = {new_exists, new_held, new_owner, new_head, new_count};
    end
  end

  qlm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_LOCKS)
  ) u_lock_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (accept),
    .raddr (LI_W'(in_lock_index)),
    .rdata (tbl_rdata)
  );

  // Waiter queues: lock li owns slots li*MAX_NODES .. li*MAX_NODES+MAX_NODES-1
  assign wq_we   = act && dec.q_we;
  assign wq_re   = act && dec.q_re;
  assign wq_addr = WA_W'(li) * WA_W'(MAX_NODES) + WA_W'(slot);

  qlm_ram #(
    .WIDTH (WQ_W),
    .DEPTH (WQ_D)
  ) u_waiter_store (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_addr),
    .wdata ({req_node_r, req_seq_r}),
    .re    (wq_re),
    .raddr (wq_addr),
    .rdata (wq_rdata)
  );

  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r <= kind_t'(in_kind);
      req_idx_r  <= in_lock_index;
      req_node_r <= in_source_node;
      req_seq_r  <= in_source_seq;
    end
  end

  // Result capture; destination fields read zero when no message goes out
  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= dec.status;
      out_send_r   <= dec.send;
      if (!dec.send) begin
        out_node_r <= '0;
        out_seq_r  <= '0;
      end else if (dec.from_waiter) begin
        out_node_r <= waiter_node;
        out_seq_r  <= waiter_seq;
      end else begin
        out_node_r <= req_node_r;
        out_seq_r  <= req_seq_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_send_valid = out_send_r;
  assign out_dest_node  = out_node_r;
  assign out_dest_seq   = out_seq_r;

endmodule

// ===== src/qlm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module qlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/qlm_decide.sv =====
// Request decision: status, table update and queue access for one lock entry.
`timescale 1ns / 1ps

module qlm_decide #(
  parameter int  MAX_NODES = qlm_pkg::DEF_MAX_NODES,
  localparam int HD_W      = $clog2(MAX_NODES),
  localparam int CT_W      = $clog2(MAX_NODES + 1)
) (
  input  logic                     deq_phase,
  input  qlm_pkg::kind_t           req_kind,
  input  logic                     req_idx_ok,
  input  logic [qlm_pkg::NODE_W-1:0] req_node,
  input  logic                     ent_exists,
  input  logic                     ent_held,
  input  logic [qlm_pkg::NODE_W-1:0] ent_owner,
  input  logic [HD_W-1:0]          ent_head,
  input  logic [CT_W-1:0]          ent_count,
  input  logic [qlm_pkg::NODE_W-1:0] waiter_node,
  output qlm_pkg::dec_t            dec,
  output logic                     new_exists,
  output logic                     new_held,
  output logic [qlm_pkg::NODE_W-1:0] new_owner,
  output logic [HD_W-1:0]          new_head,
  output logic [CT_W-1:0]          new_count,
  output logic [HD_W-1:0]          slot
);

  import qlm_pkg::*;

  localparam int SUM_W = CT_W + 1;

  logic [SUM_W-1:0] tail_sum;
  logic [HD_W-1:0]  push_slot;
  logic [HD_W:0]    head_inc;
  logic [HD_W-1:0]  head_next;
  logic             q_full;
  logic             q_empty;

  // Tail slot wraps once at most: head is below the depth and count at most equal to it
  assign tail_sum  = SUM_W'(ent_head) + SUM_W'(ent_count);
  assign push_slot = (tail_sum >= SUM_W'(MAX_NODES)) ?
                     HD_W'(tail_sum - SUM_W'(MAX_NODES)) : HD_W'(tail_sum);
  assign head_inc  = (HD_W + 1)'(ent_head) + (HD_W + 1)'(1);
  assign head_next = (head_inc == (HD_W + 1)'(MAX_NODES)) ? '0 : HD_W'(head_inc);
  assign q_full    = (ent_count >= CT_W'(MAX_NODES));
  assign q_empty   = (ent_count == '0);
  assign slot      = (req_kind == KIND_LOCK) ? push_slot : ent_head;

  always_comb begin
    dec         = '{status: STS_OK, send: 1'b0, tbl_we: 1'b0, q_we: 1'b0,
                    q_re: 1'b0, from_waiter: 1'b0};
    new_exists  = ent_exists;
    new_held    = ent_held;
    new_owner   = ent_owner;
    new_head    = ent_head;
    new_count   = ent_count;

    if (deq_phase) begin
      // Hand-over to the oldest waiter
      dec.send        = 1'b1;
      dec.from_waiter = 1'b1;
      dec.tbl_we      = 1'b1;
      new_owner       = waiter_node;
      new_head        = head_next;
      new_count       = ent_count - CT_W'(1);
    end else begin
      unique case (req_kind)
        KIND_NOP: begin
          dec.status = STS_OK;
        end
        KIND_INIT: begin
          priority if (!req_idx_ok) begin
            dec.status = STS_UNKNOWN;
          end else begin
            dec.send = 1'b1;
            if (!ent_exists) begin
              dec.tbl_we = 1'b1;
              new_exists = 1'b1;
              new_held   = 1'b0;
              new_owner  = '0;
              new_head   = '0;
              new_count  = '0;
            end
          end
        end
        KIND_LOCK: begin
          priority if (!req_idx_ok || !ent_exists) begin
            dec.status = STS_UNKNOWN;
          end else if (!ent_held) begin
            dec.send   = 1'b1;
            dec.tbl_we = 1'b1;
            new_held   = 1'b1;
            new_owner  = req_node;
          end else if (q_full) begin
            dec.status = STS_FULL;
          end else begin
            dec.status = STS_QUEUED;
            dec.q_we   = 1'b1;
            dec.tbl_we = 1'b1;
            new_count  = ent_count + CT_W'(1);
          end
        end
        KIND_UNLOCK: begin
          priority if (!req_idx_ok || !ent_exists) begin
            dec.status = STS_UNKNOWN;
          end else if (ent_owner != req_node) begin
            dec.status = STS_NOT_OWNER;
          end else if (!ent_held) begin
            dec.status = STS_NOT_HELD;
          end else if (q_empty) begin
            dec.tbl_we = 1'b1;
            new_held   = 1'b0;
          end else begin
            // Fetch the head waiter; the result is decided in the dequeue phase
            dec.q_re = 1'b1;
          end
        end
        default: begin
          dec.status = STS_OK;
        end
      endcase
    end
  end

endmodule
